@@ rtl/core/sis_pkg.sv @@
// ----------------------------------------------------------------------------
// sis_pkg: shared types and codes for the sorted interval set unit
// Command and status codes, item payload structs.
// ----------------------------------------------------------------------------
`default_nettype none
package sis_pkg;
    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_GET      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_INDEX = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] range_low;
        logic [63:0] range_high;
        logic [7:0]  entry_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        covered;
        logic [63:0] entry_low;
        logic [63:0] entry_high;
        logic [4:0]  entry_count;
        logic [63:0] total_bytes;
        logic        total_overflow;
    } rsp_t;
endpackage
`default_nettype wire

@@ rtl/core/sis_if.sv @@
// ----------------------------------------------------------------------------
// sis_req_if / sis_rsp_if: valid/ready channels
// One item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none
interface sis_req_if;
    logic          valid;
    logic          ready;
    sis_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sis_rsp_if;
    logic          valid;
    logic          ready;
    sis_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sorted_interval_set_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_interval_set_unit: sorted table of disjoint half-open ranges
// Add / remove / contains / get with running byte total.
// ----------------------------------------------------------------------------
// The slowest item is an add or remove that drops most entries: each drop shifts
//   the tail one entry per cycle. Contains and get walk the table, and the byte
//   total takes every entry's length through the shared adder.
// Throughput: one item at a time; ready is low while an item is in work.
// Reset: asynchronous, clears the entry count and control; table contents
//   are undefined until written.
`default_nettype none
module sorted_interval_set_unit #(
    parameter int MAX_RANGES = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sis_req_if.sink   req,
    sis_rsp_if.source rsp
);
    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_ASCAN, S_AMERGE, S_RSCAN, S_CSCAN,
        S_SHUP, S_SHDN, S_WRITE, S_SUM, S_ACC, S_DONE
    } state_t;

    logic [63:0] starts_mem [MAX_RANGES];
    logic [63:0] ends_mem   [MAX_RANGES];

    state_t        state_reg;
    logic [CW-1:0] used_reg;
    sis_pkg::req_t q_reg;
    logic [63:0]   lo_reg, hi_reg;
    logic [CW-1:0] i_reg, first_reg, last_reg, k_reg, wpos_reg;
    logic [63:0]   wlo_reg, whi_reg, plo_reg, phi_reg;
    logic          pend_reg;
    logic [63:0]   sum_reg;
    logic [63:0]   len_reg;
    logic          ovf_reg;
    sis_pkg::rsp_t r_reg;
    logic          rvalid_reg;

    logic [IW-1:0] ii, kk, km1, kp1;
    assign ii  = i_reg[IW-1:0];
    assign kk  = k_reg[IW-1:0];
    assign km1 = IW'(k_reg - CW'(1));
    assign kp1 = IW'(k_reg + CW'(1));

    logic [63:0] s_i, e_i;
    assign s_i = starts_mem[ii];
    assign e_i = ends_mem[ii];

    logic [63:0] alu_y;
    logic        alu_c;
    logic [63:0] alu_a, alu_b;
    logic        alu_sub;
    always_comb
    begin
        alu_a   = e_i;
        alu_b   = s_i;
        alu_sub = 1'b1;
        if (state_reg == S_ACC)
        begin
            alu_a   = sum_reg;
            alu_b   = len_reg;
            alu_sub = 1'b0;
        end
    end
    sis_alu u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .y(alu_y), .carry(alu_c));

    assign req.ready = (state_reg == S_IDLE) && !rvalid_reg;
    assign rsp.valid = rvalid_reg;
    assign rsp.data  = r_reg;

    logic at_end;
    assign at_end = (i_reg >= used_reg);

    // add merge with no entry left to drop
    logic merge_done;
    assign merge_done = (q_reg.cmd == sis_pkg::CMD_ADD) &&
                        (last_reg <= first_reg + CW'(1));

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SHUP)
        begin
            starts_mem[kk] <= starts_mem[km1];
            ends_mem[kk]   <= ends_mem[km1];
        end
        else if (state_reg == S_SHDN && !merge_done)
        begin
            starts_mem[kk] <= starts_mem[kp1];
            ends_mem[kk]   <= ends_mem[kp1];
        end
        else if (state_reg == S_WRITE)
        begin
            starts_mem[wpos_reg[IW-1:0]] <= wlo_reg;
            ends_mem[wpos_reg[IW-1:0]]   <= whi_reg;
            if (pend_reg)
            begin
                starts_mem[IW'(wpos_reg + CW'(1))] <= plo_reg;
                ends_mem[IW'(wpos_reg + CW'(1))]   <= phi_reg;
            end
        end
        else if (state_reg == S_RSCAN && !at_end && !(hi_reg <= s_i) &&
                 !(lo_reg >= e_i))
        begin
            if (lo_reg <= s_i && !(hi_reg >= e_i))
                starts_mem[ii] <= hi_reg;
            else if (!(lo_reg <= s_i) && hi_reg >= e_i)
                ends_mem[ii] <= lo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            rvalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (rvalid_reg && rsp.ready)
                rvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        q_reg  <= req.data;
                        lo_reg <= req.data.range_low;
                        hi_reg <= req.data.range_high;
                        r_reg  <= '0;
                        i_reg  <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    pend_reg <= 1'b0;
                    if (q_reg.cmd == sis_pkg::CMD_GET)
                    begin
                        if ({1'b0, q_reg.entry_index} >= 9'(used_reg))
                            r_reg.status <= sis_pkg::ST_INDEX;
                        else
                        begin
                            r_reg.entry_low  <= starts_mem[IW'(q_reg.entry_index)];
                            r_reg.entry_high <= ends_mem[IW'(q_reg.entry_index)];
                        end
                        state_reg <= S_SUM;
                    end
                    else if (lo_reg >= hi_reg)
                    begin
                        r_reg.status <= sis_pkg::ST_RANGE;
                        state_reg <= S_SUM;
                    end
                    else if (q_reg.cmd == sis_pkg::CMD_ADD)
                        state_reg <= S_ASCAN;
                    else if (q_reg.cmd == sis_pkg::CMD_REMOVE)
                        state_reg <= S_RSCAN;
                    else
                        state_reg <= S_CSCAN;
                    sum_reg <= '0;
                    ovf_reg <= 1'b0;
                    if (q_reg.cmd == sis_pkg::CMD_GET || lo_reg >= hi_reg)
                        i_reg <= '0;
                end
                S_ASCAN:
                begin
                    if (!at_end && e_i < lo_reg)
                        i_reg <= i_reg + CW'(1);
                    else
                    begin
                        first_reg <= i_reg;
                        state_reg <= S_AMERGE;
                    end
                end
                S_AMERGE:
                begin
                    if (!at_end && s_i <= hi_reg)
                    begin
                        if (s_i < lo_reg) lo_reg <= s_i;
                        if (e_i > hi_reg) hi_reg <= e_i;
                        i_reg <= i_reg + CW'(1);
                    end
                    else
                    begin
                        last_reg <= i_reg;
                        wpos_reg <= first_reg;
                        wlo_reg  <= lo_reg;
                        whi_reg  <= hi_reg;
                        if (i_reg == first_reg)
                        begin
                            if (used_reg >= CW'(MAX_RANGES))
                            begin
                                r_reg.status <= sis_pkg::ST_FULL;
                                i_reg <= '0;
                                state_reg <= S_SUM;
                            end
                            else
                            begin
                                k_reg <= used_reg;
                                state_reg <= S_SHUP;
                            end
                        end
                        else
                        begin
                            // drop entries first+1 .. last-1
                            k_reg <= first_reg + CW'(1);
                            state_reg <= S_SHDN;
                        end
                    end
                end
                S_RSCAN:
                begin
                    if (at_end || hi_reg <= s_i)
                    begin
                        i_reg <= '0;
                        state_reg <= S_SUM;
                    end
                    else if (lo_reg >= e_i)
                        i_reg <= i_reg + CW'(1);
                    else if (lo_reg <= s_i && hi_reg >= e_i)
                    begin
                        wpos_reg <= i_reg;
                        first_reg <= i_reg;
                        last_reg <= i_reg + CW'(1);
                        k_reg <= i_reg;
                        pend_reg <= 1'b0;
                        state_reg <= S_SHDN;
                    end
                    else if (lo_reg <= s_i)
                    begin
                        i_reg <= '0;
                        state_reg <= S_SUM;
                    end
                    else if (hi_reg >= e_i)
                        i_reg <= i_reg + CW'(1);
                    else if (used_reg >= CW'(MAX_RANGES))
                    begin
                        r_reg.status <= sis_pkg::ST_FULL;
                        i_reg <= '0;
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        wpos_reg <= i_reg;
                        wlo_reg  <= s_i;
                        whi_reg  <= lo_reg;
                        plo_reg  <= hi_reg;
                        phi_reg  <= e_i;
                        pend_reg <= 1'b1;
                        k_reg    <= used_reg;
                        first_reg <= i_reg + CW'(1);
                        state_reg <= S_SHUP;
                    end
                end
                S_CSCAN:
                begin
                    if (at_end || lo_reg < s_i)
                    begin
                        i_reg <= '0;
                        state_reg <= S_SUM;
                    end
                    else if (hi_reg <= e_i)
                    begin
                        r_reg.covered <= 1'b1;
                        i_reg <= '0;
                        state_reg <= S_SUM;
                    end
                    else
                        i_reg <= i_reg + CW'(1);
                end
                S_SHUP:
                begin
                    // open a gap at first_reg (add) or first_reg (split tail)
                    if (k_reg > (pend_reg ? first_reg : wpos_reg))
                        k_reg <= k_reg - CW'(1);
                    else
                    begin
                        used_reg <= used_reg + CW'(1);
                        state_reg <= S_WRITE;
                    end
                end
                S_SHDN:
                begin
                    // remove one entry at first_reg+1 (add merge) or at wpos_reg (remove)
                    if (merge_done)
                        state_reg <= S_WRITE;
                    else if (k_reg + CW'(1) < used_reg)
                        k_reg <= k_reg + CW'(1);
                    else
                    begin
                        used_reg <= used_reg - CW'(1);
                        if (q_reg.cmd == sis_pkg::CMD_ADD)
                        begin
                            last_reg <= last_reg - CW'(1);
                            k_reg <= first_reg + CW'(1);
                        end
                        else
                        begin
                            i_reg <= wpos_reg;
                            state_reg <= S_RSCAN;
                        end
                    end
                end
                S_WRITE:
                begin
                    pend_reg <= 1'b0;
                    i_reg <= '0;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    // length of entry i through the shared unit
                    if (at_end || ovf_reg)
                        state_reg <= S_DONE;
                    else
                    begin
                        len_reg <= alu_y;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (alu_c)
                        ovf_reg <= 1'b1;
                    else
                        sum_reg <= alu_y;
                    i_reg <= i_reg + CW'(1);
                    state_reg <= S_SUM;
                end
                S_DONE:
                begin
                    r_reg.entry_count    <= 5'(used_reg);
                    r_reg.total_bytes    <= ovf_reg ? 64'd0 : sum_reg;
                    r_reg.total_overflow <= ovf_reg;
                    rvalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/sis_alu.sv @@
// ----------------------------------------------------------------------------
// sis_alu: shared 64-bit add/subtract unit
// Result plus carry out; sub computes a - b with carry = no borrow.
// ----------------------------------------------------------------------------
`default_nettype none
module sis_alu (
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    input  wire logic        sub,
    output logic [63:0]      y,
    output logic             carry
);
    logic [64:0] sum;
    assign sum   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {64'd0, sub};
    assign y     = sum[63:0];
    assign carry = sum[64];
endmodule
`default_nettype wire

@@ rtl/core/sis_checker.sv @@
// ----------------------------------------------------------------------------
// sis_checker: port-level checks for sorted_interval_set_unit
// Bound into sorted_interval_set_unit.
// ----------------------------------------------------------------------------
`default_nettype none
module sis_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic [1:0] status,
    input wire logic covered,
    input wire logic [4:0] entry_count,
    input wire logic [63:0] total_bytes,
    input wire logic total_overflow
);
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready) else $error("ready after accept");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && total_overflow |-> total_bytes == 64'd0) else $error("ovf sum");
    a_cov: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && covered |-> status == 2'd0) else $error("covered status");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && entry_count == 5'd0 |-> total_bytes == 64'd0 && !covered)
        else $error("empty table");
endmodule

bind sorted_interval_set_unit sis_checker u_sis_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .status(rsp.data.status), .covered(rsp.data.covered),
    .entry_count(rsp.data.entry_count), .total_bytes(rsp.data.total_bytes),
    .total_overflow(rsp.data.total_overflow)
);
`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for sorted_interval_set_unit
// Drives add/remove/contains/get items, predicts each result from a local
// copy of the range table and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    localparam int NRANGE = 16;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    sis_req_if req_ch();
    sis_rsp_if rsp_ch();

    sorted_interval_set_unit #(.MAX_RANGES(NRANGE)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch.sink),
        .rsp(rsp_ch.source)
    );

    logic [63:0] tbl_lo[NRANGE];
    logic [63:0] tbl_hi[NRANGE];
    int unsigned tbl_used;

    sis_pkg::req_t pending_reqs[$];
    sis_pkg::rsp_t expected_rsps[$];
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_send;
    bit   stim_done;
    bit   req_taken;
    int   errors;
    int   quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic void tbl_drop(int unsigned pos);
        for (int unsigned k = pos; k + 1 < tbl_used; k++)
        begin
            tbl_lo[k] = tbl_lo[k + 1];
            tbl_hi[k] = tbl_hi[k + 1];
        end
        tbl_used--;
    endfunction

    function automatic void tbl_gap(int unsigned pos);
        for (int unsigned k = tbl_used; k > pos; k--)
        begin
            tbl_lo[k] = tbl_lo[k - 1];
            tbl_hi[k] = tbl_hi[k - 1];
        end
        tbl_used++;
    endfunction

    function automatic sis_pkg::status_t range_add(logic [63:0] lo, logic [63:0] hi);
        int unsigned first;
        int unsigned last;
        first = 0;
        while (first < tbl_used && tbl_hi[first] < lo)
            first++;
        last = first;
        while (last < tbl_used && tbl_lo[last] <= hi)
        begin
            if (tbl_lo[last] < lo)
                lo = tbl_lo[last];
            if (tbl_hi[last] > hi)
                hi = tbl_hi[last];
            last++;
        end
        if (first == last)
        begin
            if (tbl_used >= NRANGE)
                return sis_pkg::ST_FULL;
            tbl_gap(first);
        end
        else
        begin
            while (last > first + 1)
            begin
                tbl_drop(first + 1);
                last--;
            end
        end
        tbl_lo[first] = lo;
        tbl_hi[first] = hi;
        return sis_pkg::ST_OK;
    endfunction

    function automatic sis_pkg::status_t range_remove(logic [63:0] lo, logic [63:0] hi);
        int unsigned i;
        logic [63:0] s;
        logic [63:0] e;
        i = 0;
        while (i < tbl_used)
        begin
            s = tbl_lo[i];
            e = tbl_hi[i];
            if (hi <= s)
                break;
            if (lo >= e)
                i++;
            else if (lo <= s && hi >= e)
                tbl_drop(i);
            else if (lo <= s)
            begin
                tbl_lo[i] = hi;
                break;
            end
            else if (hi >= e)
            begin
                tbl_hi[i] = lo;
                i++;
            end
            else
            begin
                if (tbl_used >= NRANGE)
                    return sis_pkg::ST_FULL;
                tbl_gap(i + 1);
                tbl_lo[i + 1] = hi;
                tbl_hi[i + 1] = e;
                tbl_hi[i] = lo;
                break;
            end
        end
        return sis_pkg::ST_OK;
    endfunction

    function automatic logic range_covers(logic [63:0] lo, logic [63:0] hi);
        for (int unsigned i = 0; i < tbl_used; i++)
        begin
            if (lo < tbl_lo[i])
                return 1'b0;
            if (hi <= tbl_hi[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic sis_pkg::rsp_t predict_rsp(sis_pkg::req_t r);
        sis_pkg::rsp_t o;
        logic [64:0] sum;
        o = '0;
        if (r.cmd == sis_pkg::CMD_GET)
        begin
            if (r.entry_index >= tbl_used)
                o.status = sis_pkg::ST_INDEX;
            else
            begin
                o.entry_low = tbl_lo[r.entry_index];
                o.entry_high = tbl_hi[r.entry_index];
            end
        end
        else if (r.range_low >= r.range_high)
            o.status = sis_pkg::ST_RANGE;
        else if (r.cmd == sis_pkg::CMD_ADD)
            o.status = range_add(r.range_low, r.range_high);
        else if (r.cmd == sis_pkg::CMD_REMOVE)
            o.status = range_remove(r.range_low, r.range_high);
        else
            o.covered = range_covers(r.range_low, r.range_high);
        sum = '0;
        for (int unsigned i = 0; i < tbl_used; i++)
        begin
            sum = {1'b0, sum[63:0]} + {1'b0, tbl_hi[i] - tbl_lo[i]};
            if (sum[64])
            begin
                o.total_overflow = 1'b1;
                break;
            end
        end
        o.total_bytes = o.total_overflow ? 64'd0 : sum[63:0];
        o.entry_count = tbl_used[4:0];
        return o;
    endfunction

    // driver; the monitor pops an item once it is accepted
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data <= '0;
        end
        else if (!req_ch.valid || req_taken)
        begin
            if (pending_reqs.size() > 0 && !hold_send
                && $urandom_range(99) >= send_idle_pct)
            begin
                req_ch.valid <= 1'b1;
                req_ch.data <= pending_reqs[0];
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsps.push_back(predict_rsp(req_ch.data));
                pending_reqs.pop_front();
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                    report("unexpected item", 64'd0, 64'd0);
                else
                begin
                    sis_pkg::rsp_t w;
                    sis_pkg::rsp_t g;
                    w = expected_rsps.pop_front();
                    g = rsp_ch.data;
                    if (g.status !== w.status) report("status", g.status, w.status);
                    if (g.covered !== w.covered) report("covered", g.covered, w.covered);
                    if (g.entry_low !== w.entry_low)
                        report("entry_low", g.entry_low, w.entry_low);
                    if (g.entry_high !== w.entry_high)
                        report("entry_high", g.entry_high, w.entry_high);
                    if (g.entry_count !== w.entry_count)
                        report("entry_count", g.entry_count, w.entry_count);
                    if (g.total_bytes !== w.total_bytes)
                        report("total_bytes", g.total_bytes, w.total_bytes);
                    if (g.total_overflow !== w.total_overflow)
                        report("total_overflow", g.total_overflow, w.total_overflow);
                end
            end
            if (quiet_cycles > STALL_LIMIT)
            begin
                $display("timeout");
                $display("FAIL sorted_interval_set_unit");
                $finish;
            end
        end
    end

    function automatic sis_pkg::req_t make_req(sis_pkg::cmd_t c, logic [63:0] lo,
                                               logic [63:0] hi, logic [7:0] idx);
        sis_pkg::req_t r;
        r.cmd = c;
        r.range_low = lo;
        r.range_high = hi;
        r.entry_index = idx;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mostly a small address window so ranges collide; sometimes full width
    function automatic sis_pkg::req_t random_req();
        logic [63:0] lo;
        logic [63:0] hi;
        sis_pkg::cmd_t c;
        int sel;
        c = sis_pkg::cmd_t'($urandom_range(3));
        sel = $urandom_range(99);
        if (sel < 75)
        begin
            lo = 64'($urandom_range(400));
            hi = lo + 64'($urandom_range(40));
        end
        else if (sel < 90)
        begin
            lo = rand64();
            hi = rand64();
        end
        else
        begin
            lo = 64'hFFFF_FFFF_FFFF_FF00 - 64'($urandom_range(1000));
            hi = lo + 64'($urandom_range(300));
            if (hi < lo)
                hi = '1;
        end
        return make_req(c, lo, hi, (sel < 80) ? 8'($urandom_range(17)) : 8'($urandom()));
    endfunction

    initial
    begin
        errors = 0;
        quiet_cycles = 0;
        tbl_used = 0;
        hold_send = 1'b0;
        stim_done = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 76;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        pending_reqs.push_back(make_req(sis_pkg::CMD_GET, 0, 0, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_REMOVE, 10, 20, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_ADD, 5, 5, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_ADD, 9, 3, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_CONTAINS, 7, 7, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_ADD, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_GET, 0, 0, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_REMOVE, 100, 200, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_CONTAINS, 0, 100, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_CONTAINS, 100, 150, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_ADD, 100, 200, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_GET, 0, 0, 8'hFF));
        pending_reqs.push_back(make_req(sis_pkg::CMD_REMOVE, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0));
        for (int i = 0; i < 17; i++)
            pending_reqs.push_back(make_req(sis_pkg::CMD_ADD, 64'(i * 10),
                                            64'(i * 10 + 5), 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_REMOVE, 1, 2, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_ADD, 5, 10, 0));
        pending_reqs.push_back(make_req(sis_pkg::CMD_GET, 0, 0, 15));
        pending_reqs.push_back(make_req(sis_pkg::CMD_GET, 0, 0, 16));

        for (int phase = 0; phase < 3; phase++)
        begin
            wait (pending_reqs.size() == 0);
            if (phase == 1)
            begin
                send_idle_pct = 76;
                recv_idle_pct = 10;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            hold_send = 1'b1;
            wait (expected_rsps.size() == 0 && !rsp_ch.valid);
            @(negedge clk);
            hold_send = 1'b0;
            // clear out every few sequences so adds and splits keep working
            for (int n = 0; n < 180; n++)
            begin
                if ($urandom_range(59) == 0)
                    pending_reqs.push_back(make_req(sis_pkg::CMD_REMOVE, 0, '1, 0));
                pending_reqs.push_back(random_req());
            end
        end
        wait (pending_reqs.size() == 0);
        wait (expected_rsps.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("PASS sorted_interval_set_unit");
        else
            $display("FAIL sorted_interval_set_unit");
        $finish;
    end
endmodule
`default_nettype wire
